>>> sv/pfd_pkg.sv
package pfd_pkg;

   localparam logic [7:0] HDR_A  = 8'hCA;
   localparam logic [7:0] HDR_B  = 8'hFE;
   localparam logic [7:0] TAIL_A = 8'hEF;
   localparam logic [7:0] TAIL_B = 8'hAC;

   localparam logic [15:0] CAPACITY_RESET = 16'd256;

   typedef enum logic [3:0] {
      ST_HDR1  = 4'd0,
      ST_HDR2  = 4'd1,
      ST_TYPE  = 4'd2,
      ST_LEN1  = 4'd3,
      ST_LEN2  = 4'd4,
      ST_DATA  = 4'd5,
      ST_SKIP  = 4'd6,
      ST_SUM   = 4'd7,
      ST_TAIL1 = 4'd8,
      ST_TAIL2 = 4'd9
   } pfd_state_type;

   typedef enum logic [2:0] {
      RC_NONE   = 3'd0,
      RC_DONE   = 3'd1,
      RC_HEADER = 3'd2,
      RC_SUM    = 3'd3,
      RC_TAIL1  = 3'd4,
      RC_TAIL2  = 3'd5
   } pfd_code_type;

   typedef struct packed {
      pfd_code_type result_code;
      logic [7:0]   packet_type;
      logic [15:0]  packet_length;
      logic         store_valid;
      logic [15:0]  store_index;
      logic [7:0]   store_byte;
      logic         payload_complete;
   } pfd_rsp_type;

endpackage

>>> sv/pfd_if.sv
// received byte channel
interface pfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// per-byte result channel
interface pfd_rsp_if;
   import pfd_pkg::*;
   logic         valid;
   logic         ready;
   pfd_code_type result_code;
   logic [7:0]   packet_type;
   logic [15:0]  packet_length;
   logic         store_valid;
   logic [15:0]  store_index;
   logic [7:0]   store_byte;
   logic         payload_complete;

   modport source (output valid, output result_code, output packet_type,
                   output packet_length, output store_valid, output store_index,
                   output store_byte, output payload_complete, input ready);
   modport sink   (input valid, input result_code, input packet_type,
                   input packet_length, input store_valid, input store_index,
                   input store_byte, input payload_complete, output ready);
endinterface

// capacity register write channel
interface pfd_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> sv/packet_frame_decoder.sv
// Packet frame decoder: byte-serial deframer for
//   0xCA 0xFE | type | len lo | len hi | payload | sum | 0xEF 0xAC
// req_ch  : one received byte per item (rx_byte).
// rsp_ch  : exactly one result item per byte: result code, current type and
//           length, a payload store write (valid, index, byte) and a pulse on
//           the last stored payload byte.
// csr_ch  : writes buffer_capacity; always ready. Write only while idle.
// Result: each accepted byte's result is registered before it shows on rsp_ch.
// Throughput: one byte per cycle while req_ch.ready is high; the state update
// is one compare/add pass between the accept edge and the result register.
// Stall: a result register plus one skid register; while the receiver stalls
// one more byte is taken into the skid register, then req_ch.ready drops
// until the receiver takes a result. No result is lost or repeated.
// Reset (synchronous, active high): frame state waits for the first header
// byte, sum/type/length/position clear, capacity returns to 256, both result
// registers empty.
module packet_frame_decoder
   import pfd_pkg::*;
(
   input logic      clock,
   input logic      reset,
   pfd_req_if.sink  req_ch,
   pfd_rsp_if.source rsp_ch,
   pfd_csr_if.sink  csr_ch
);

   // frame state registers
   pfd_state_type state_ff, state_in;
   logic [7:0]    sum_ff, sum_in;
   logic [7:0]    type_ff, type_in;
   logic [15:0]   len_ff, len_in;
   logic [15:0]   pos_ff, pos_in;
   logic [15:0]   cap_ff;

   // result register and skid register
   pfd_rsp_type out_ff, out_in, skid_ff, skid_in, res;
   logic        out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic        accept, pop;
   logic [7:0]  b;
   logic [7:0]  sum_add;
   logic [15:0] len_full;
   logic [15:0] pos_inc;

   assign b        = req_ch.rx_byte;
   assign sum_add  = sum_ff + b;
   assign len_full = {b, len_ff[7:0]};
   assign pos_inc  = pos_ff + 16'd1;

   assign req_ch.ready = !skid_valid_ff;
   assign csr_ch.ready = 1'b1;
   assign accept = req_ch.valid && req_ch.ready;
   assign pop    = out_valid_ff && rsp_ch.ready;

   // next frame state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_HDR1: begin
            if (b == HDR_A) state_in = ST_HDR2;
         end
         ST_HDR2: begin
            if (b == HDR_A) state_in = ST_HDR2;
            else if (b == HDR_B) state_in = ST_TYPE;
            else state_in = ST_HDR1;
         end
         ST_TYPE: state_in = ST_LEN1;
         ST_LEN1: state_in = ST_LEN2;
         ST_LEN2: begin
            if (len_full == 16'd0) state_in = ST_SUM;
            else if (len_full < cap_ff) state_in = ST_DATA;
            else state_in = ST_SKIP;
         end
         ST_DATA, ST_SKIP: begin
            if (pos_inc == len_ff) state_in = ST_SUM;
         end
         ST_SUM: begin
            if (sum_ff != b) state_in = ST_HDR1;
            else state_in = ST_TAIL1;
         end
         ST_TAIL1: begin
            if (b == TAIL_A) state_in = ST_TAIL2;
            else state_in = ST_HDR1;
         end
         ST_TAIL2: state_in = ST_HDR1;
         default:  state_in = ST_HDR1;
      endcase
   end

   // datapath and result fields
   always_comb begin
      sum_in  = (state_ff != ST_SUM) ? sum_add : sum_ff;
      type_in = type_ff;
      len_in  = len_ff;
      pos_in  = pos_ff;
      res.result_code      = RC_NONE;
      res.store_valid      = 1'b0;
      res.store_index      = 16'd0;
      res.store_byte       = 8'd0;
      res.payload_complete = 1'b0;
      case (state_ff)
         ST_HDR1: begin
            if (b == HDR_A) sum_in = HDR_A;
         end
         ST_HDR2: begin
            if (b == HDR_A) sum_in = HDR_A;
            else if (b != HDR_B) res.result_code = RC_HEADER;
         end
         ST_TYPE: type_in = b;
         ST_LEN1: len_in = {8'd0, b};
         ST_LEN2: begin
            len_in = len_full;
            pos_in = 16'd0;
         end
         ST_DATA: begin
            res.store_valid = 1'b1;
            res.store_index = pos_ff;
            res.store_byte  = b;
            pos_in = pos_inc;
            if (pos_inc == len_ff) res.payload_complete = 1'b1;
         end
         ST_SKIP: pos_in = pos_inc;
         ST_SUM: begin
            if (sum_ff != b) res.result_code = RC_SUM;
         end
         ST_TAIL1: begin
            if (b != TAIL_A) res.result_code = RC_TAIL1;
         end
         ST_TAIL2: begin
            res.result_code = (b == TAIL_B) ? RC_DONE : RC_TAIL2;
         end
         default: ;
      endcase
      res.packet_type   = type_in;
      res.packet_length = len_in;
   end

   // result / skid steering; accept only happens with the skid empty
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_HDR1;
         sum_ff        <= 8'd0;
         type_ff       <= 8'd0;
         len_ff        <= 16'd0;
         pos_ff        <= 16'd0;
         cap_ff        <= CAPACITY_RESET;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
            sum_ff   <= sum_in;
            type_ff  <= type_in;
            len_ff   <= len_in;
            pos_ff   <= pos_in;
         end
         if (csr_ch.valid) cap_ff <= csr_ch.data;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.result_code      = out_ff.result_code;
   assign rsp_ch.packet_type      = out_ff.packet_type;
   assign rsp_ch.packet_length    = out_ff.packet_length;
   assign rsp_ch.store_valid      = out_ff.store_valid;
   assign rsp_ch.store_index      = out_ff.store_index;
   assign rsp_ch.store_byte       = out_ff.store_byte;
   assign rsp_ch.payload_complete = out_ff.payload_complete;

endmodule

>>> tb/packet_frame_decoder_tb.sv
module packet_frame_decoder_tb;
   import pfd_pkg::*;

   // Stream faults that the frame builder can inject.
   typedef enum {
      FRAME_GOOD,
      FRAME_BAD_HEADER,
      FRAME_BAD_SUM,
      FRAME_BAD_TAIL1,
      FRAME_BAD_TAIL2
   } frame_fault_type;

   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int          HOLD_CYCLES  = 400;   // long receiver hold-off
   localparam int          PHASE_BYTES  = 100;   // random bytes per phase
   localparam int          PHASE_COUNT  = 6;
   localparam int          PRESSURE_PHASE = 4;
   localparam int          PRINT_LIMIT  = 50;

   logic clock;
   logic reset = 1'b1;

   pfd_req_if req_ch ();
   pfd_rsp_if rsp_ch ();
   pfd_csr_if csr_ch ();

   packet_frame_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------------
   // Shared state between stimulus, driver and monitor
   // ---------------------------------------------------------------------
   logic [7:0]  stream_bytes [$];      // bytes waiting to be offered
   pfd_rsp_type expected_results [$];  // predicted per-byte results, oldest first
   int          bytes_queued   = 0;
   int          bytes_accepted = 0;
   int          results_seen   = 0;
   int          error_count    = 0;
   int unsigned cycle_count    = 0;
   logic        byte_taken     = 1'b0; // req item accepted at the last rising edge

   // idle percentages; the stimulus process switches them per phase
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // long hold-off of the receiver; the stimulus asks, the hold process counts
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   // ---------------------------------------------------------------------
   // Decoder prediction: its own copy of the frame tracker and capacity
   // ---------------------------------------------------------------------
   pfd_state_type dec_state;
   logic [7:0]    dec_sum;
   logic [7:0]    dec_type;
   logic [15:0]   dec_length;
   logic [15:0]   dec_position;
   logic [15:0]   dec_capacity;

   task automatic reset_decoder_model();
      dec_state    = ST_HDR1;
      dec_sum      = '0;
      dec_type     = '0;
      dec_length   = '0;
      dec_position = '0;
      dec_capacity = CAPACITY_RESET;
   endtask

   // Advances the tracked frame by one received byte and returns the
   // result item the decoder must produce for it.
   function automatic pfd_rsp_type decode_byte(input logic [7:0] b);
      pfd_rsp_type r;
      r = '0;
      // the checksum byte itself is not summed
      if (dec_state != ST_SUM)
         dec_sum = dec_sum + b;
      case (dec_state)
         ST_HDR1: begin
            if (b == HDR_A) begin
               dec_sum   = HDR_A;
               dec_state = ST_HDR2;
            end
         end
         ST_HDR2: begin
            if (b == HDR_A) begin
               // repeated first header byte: start over from here
               dec_sum = HDR_A;
            end else if (b == HDR_B) begin
               dec_state = ST_TYPE;
            end else begin
               r.result_code = RC_HEADER;
               dec_state     = ST_HDR1;
            end
         end
         ST_TYPE: begin
            dec_type  = b;
            dec_state = ST_LEN1;
         end
         ST_LEN1: begin
            // only the low byte is visible until the high byte arrives
            dec_length = {8'h00, b};
            dec_state  = ST_LEN2;
         end
         ST_LEN2: begin
            dec_length   = dec_length | {b, 8'h00};
            dec_position = '0;
            if (dec_length == 16'd0)
               dec_state = ST_SUM;
            else if (dec_length < dec_capacity)
               dec_state = ST_DATA;
            else
               dec_state = ST_SKIP;
         end
         ST_DATA: begin
            r.store_valid = 1'b1;
            r.store_index = dec_position;
            r.store_byte  = b;
            dec_position  = dec_position + 16'd1;
            if (dec_position == dec_length) begin
               dec_state          = ST_SUM;
               r.payload_complete = 1'b1;
            end
         end
         ST_SKIP: begin
            // too long for the store: count through, never write
            dec_position = dec_position + 16'd1;
            if (dec_position == dec_length)
               dec_state = ST_SUM;
         end
         ST_SUM: begin
            if (dec_sum != b) begin
               r.result_code = RC_SUM;
               dec_state     = ST_HDR1;
            end else begin
               dec_state = ST_TAIL1;
            end
         end
         ST_TAIL1: begin
            if (b == TAIL_A) begin
               dec_state = ST_TAIL2;
            end else begin
               r.result_code = RC_TAIL1;
               dec_state     = ST_HDR1;
            end
         end
         ST_TAIL2: begin
            r.result_code = (b == TAIL_B) ? RC_DONE : RC_TAIL2;
            dec_state     = ST_HDR1;
         end
         default: begin
            dec_state = ST_HDR1;
         end
      endcase
      r.packet_type   = dec_type;
      r.packet_length = dec_length;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Error reporting
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT)
         $display("ERROR cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s = %0h, expected %0h",
                                   results_seen, name, got, want));
   endtask

   // ---------------------------------------------------------------------
   // Rising edge: capacity writes, byte predictions, result checks, timeout.
   // Prediction goes first; a result at this edge always belongs to an
   // earlier byte, so the queue order holds either way.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : track_and_check
      pfd_rsp_type want;
      byte_taken <= req_ch.valid && req_ch.ready;
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready)
            dec_capacity = csr_ch.data;
         if (req_ch.valid && req_ch.ready) begin
            expected_results.push_back(decode_byte(req_ch.rx_byte));
            bytes_accepted++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result item with no byte outstanding");
            end else begin
               want = expected_results.pop_front();
               check_field("result_code", 16'(rsp_ch.result_code),
                           16'(want.result_code));
               check_field("packet_type", 16'(rsp_ch.packet_type),
                           16'(want.packet_type));
               check_field("packet_length", rsp_ch.packet_length,
                           want.packet_length);
               check_field("store_valid", 16'(rsp_ch.store_valid),
                           16'(want.store_valid));
               check_field("store_index", rsp_ch.store_index, want.store_index);
               check_field("store_byte", 16'(rsp_ch.store_byte),
                           16'(want.store_byte));
               check_field("payload_complete", 16'(rsp_ch.payload_complete),
                           16'(want.payload_complete));
            end
            results_seen++;
         end
      end
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout: %0d bytes queued, %0d accepted, %0d results pending",
                  bytes_queued, bytes_accepted, expected_results.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Byte driver: falling edge. An offered byte stays put until taken;
   // after that a random idle may be inserted before the next one.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : drive_bytes
      logic       offer;
      logic [7:0] next_byte;
      offer     = !reset && req_ch.valid && !byte_taken;
      next_byte = req_ch.rx_byte;
      if (!reset && !offer && stream_bytes.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
         offer     = 1'b1;
         next_byte = stream_bytes.pop_front();
      end
      req_ch.valid   <= offer;
      req_ch.rx_byte <= next_byte;
   end

   // Receiver: random stalls, plus the long hold-off when one is running.
   always @(negedge clock) begin
      rsp_ch.ready <= !reset && hold_left == 0 &&
                      $urandom_range(99) >= recv_stall_pct;
   end

   // Long hold-off counter; the sender keeps offering meanwhile, so the
   // decoder's two result registers fill and req_ch.ready must drop.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         hold_left   <= HOLD_CYCLES;
         hold_served <= hold_served + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_byte(input logic [7:0] b);
      stream_bytes.push_back(b);
      bytes_queued++;
   endtask

   // Builds one frame with a random payload; the fault picks what breaks.
   task automatic queue_frame(input frame_fault_type fault, input logic [7:0] ftype,
                              input logic [15:0] length);
      logic [7:0] sum;
      logic [7:0] b;
      int         i;
      queue_byte(HDR_A);
      if (fault == FRAME_BAD_HEADER) begin
         do b = 8'($urandom_range(255)); while (b == HDR_A || b == HDR_B);
         queue_byte(b);
      end else begin
         sum = HDR_A + HDR_B + ftype + length[7:0] + length[15:8];
         queue_byte(HDR_B);
         queue_byte(ftype);
         queue_byte(length[7:0]);
         queue_byte(length[15:8]);
         for (i = 0; i < length; i++) begin
            b   = 8'($urandom_range(255));
            sum = sum + b;
            queue_byte(b);
         end
         if (fault == FRAME_BAD_SUM)
            queue_byte(sum ^ 8'($urandom_range(1, 255)));
         else
            queue_byte(sum);
         if (fault == FRAME_BAD_TAIL1) begin
            do b = 8'($urandom_range(255)); while (b == TAIL_A);
            queue_byte(b);
            queue_byte(TAIL_B);   // now just line noise
         end else begin
            queue_byte(TAIL_A);
            if (fault == FRAME_BAD_TAIL2) begin
               do b = 8'($urandom_range(255)); while (b == TAIL_B);
               queue_byte(b);
            end else begin
               queue_byte(TAIL_B);
            end
         end
      end
   endtask

   // Mostly well-formed frames with random content; the rest broken frames
   // and line noise. Noise never carries the second header byte, so it
   // cannot open a frame with a random (possibly huge) length.
   task automatic queue_random_traffic(input int budget);
      int         start;
      int         pick;
      int         n;
      logic [15:0] length;
      logic [7:0] b;
      start = bytes_queued;
      while (bytes_queued - start < budget) begin
         pick   = $urandom_range(99);
         length = ($urandom_range(9) == 0) ? 16'($urandom_range(13, 40))
                                           : 16'($urandom_range(0, 12));
         if (pick < 8)
            queue_byte(HDR_A);    // doubled first header byte -> resync
         if (pick < 70) begin
            queue_frame(FRAME_GOOD, 8'($urandom_range(255)), length);
         end else if (pick < 76) begin
            queue_frame(FRAME_BAD_SUM, 8'($urandom_range(255)), length);
         end else if (pick < 82) begin
            queue_frame(FRAME_BAD_TAIL1, 8'($urandom_range(255)), length);
         end else if (pick < 88) begin
            queue_frame(FRAME_BAD_TAIL2, 8'($urandom_range(255)), length);
         end else if (pick < 93) begin
            queue_frame(FRAME_BAD_HEADER, 8'h00, 16'd0);
         end else begin
            n = $urandom_range(1, 4);
            repeat (n) begin
               do b = 8'($urandom_range(255)); while (b == HDR_B);
               queue_byte(b);
            end
         end
      end
   endtask

   // Idle = every queued byte taken and every predicted result checked.
   task automatic wait_for_idle();
      while (stream_bytes.size() != 0 || bytes_accepted != bytes_queued ||
             expected_results.size() != 0)
         @(negedge clock);
   endtask

   // Capacity writes only happen with the decoder idle.
   task automatic write_capacity(input logic [15:0] value);
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.data  = value;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
         default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      logic [15:0] capacity;
      int          p;
      csr_ch.valid   = 1'b0;
      csr_ch.data    = '0;
      reset_decoder_model();
      set_idling(0);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed, at reset capacity: garbage extremes, bad second header
      // byte, doubled first header byte into a zero-length frame, and a
      // short stored frame with the largest type value.
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_byte(HDR_A);
      queue_byte(8'h12);
      queue_byte(HDR_A);
      queue_frame(FRAME_GOOD, 8'h00, 16'd0);
      queue_frame(FRAME_GOOD, 8'hFF, 16'd2);
      wait_for_idle();

      // Length with a nonzero high byte equal to capacity is skipped, a
      // shorter one is stored. No idling, keeps it quick.
      write_capacity(16'h0100);
      queue_frame(FRAME_GOOD, 8'h5A, 16'h0100);
      queue_frame(FRAME_GOOD, 8'hA5, 16'd20);
      wait_for_idle();

      // Random phases; capacities straddle the short lengths so both the
      // store path and the skip path are busy, with zero as the low end.
      for (p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: capacity = 16'd0;
            1: capacity = 16'd1;
            2: capacity = 16'd5;
            3: capacity = 16'd12;
            4: capacity = 16'hFFFF;
            default: capacity = 16'($urandom_range(2, 30));
         endcase
         write_capacity(capacity);
         set_idling(p % 4);
         queue_random_traffic(PHASE_BYTES);
         if (p == PRESSURE_PHASE)
            hold_requests++;
         wait_for_idle();
      end

      // keep clocking so a stray extra result would still show up
      repeat (8) @(negedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
